// ===== src/ptrr_pkg.sv =====
// Package for the process table round-robin scheduler.
// Holds table sizing, status and op codes, pid and sleep constants and the entry and port types; no dependencies.
`timescale 1ns / 1ps
package ptrr_pkg;
   localparam int ENTRIES = 128;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = IDX_W + 1;

   typedef enum logic [2:0] {
      ST_FREE    = 3'd0,
      ST_NEW     = 3'd1,
      ST_READY   = 3'd2,
      ST_RUNNING = 3'd3,
      ST_BLOCKED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      OP_ALLOC    = 4'd0,
      OP_NEW      = 4'd1,
      OP_READY    = 4'd2,
      OP_RUNNING  = 4'd3,
      OP_PAGE     = 4'd4,
      OP_SCHEDULE = 4'd5,
      OP_SLEEP    = 4'd6,
      OP_EXIT     = 4'd7,
      OP_TICK     = 4'd8,
      OP_GETPID   = 4'd9
   } op_type;

   localparam logic [15:0] PID_NONE      = 16'hFFFF;
   localparam logic [15:0] SLEEP_DEFAULT = 16'd5;

   // one table entry: status, pid, parent pid, countdown, page base
   typedef struct packed {
      status_type  status;
      logic [15:0] pid;
      logic [15:0] parent_pid;
      logic [15:0] countdown;
      logic [31:0] page_base;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [IDX_W-1:0]     wr_addr;
      entry_type            wr_data;
      logic [IDX_W-1:0]     rd_addr;
   } mem_ctl_type;
endpackage

// ===== src/process_table_round_robin_scheduler.sv =====
// Top level of the process table round-robin scheduler.
// Instantiates ptrr_table and ptrr_ctrl; uses ptrr_pkg.
`timescale 1ns / 1ps
// One word in, one word out, one at a time: req_stall stays high from the accept
// until the response word has been taken. After reset the table is cleared
// while req_stall is high. After the accept, an unknown op goes straight to the
// response; get pid first reads the slot, and new, ready, running and set page
// base read and then write it. Alloc sweeps the table one slot a cycle through
// the single memory read port until it finds a free slot (up to ENTRIES slots),
// tick always sweeps all ENTRIES slots; schedule checks up to ENTRIES-1 slots plus
// a write-back, and sleep and exit first add a read and a write of the current slot.
// The next request can be accepted in the cycle after the response is taken.
module process_table_round_robin_scheduler (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [15:0]        csr_default_sleep,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_op,
   input  logic [6:0]         req_slot,
   input  logic signed [15:0] req_pid,
   input  logic signed [15:0] req_parent_pid,
   input  logic [31:0]        req_page_base,
   input  logic [15:0]        req_sleep_ticks,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_result_slot,
   output logic               rsp_found,
   output logic signed [15:0] rsp_result_pid,
   output logic [31:0]        rsp_result_page_base
);
   import ptrr_pkg::*;

   mem_ctl_type ctl;
   entry_type   rd_data;
   logic        clear_done;

   ptrr_table u_table (
      .clock, .reset, .ctl, .rd_data, .clear_done
   );

   ptrr_ctrl u_ctrl (
      .clock, .reset, .clear_done,
      .csr_write, .csr_wdata(csr_default_sleep),
      .req_valid, .req_stall, .req_op, .req_slot, .req_pid, .req_parent_pid,
      .req_page_base, .req_sleep_ticks,
      .rsp_valid, .rsp_stall, .rsp_result_slot, .rsp_found, .rsp_result_pid,
      .rsp_result_page_base, .ctl, .rd_data
   );
endmodule

// ===== src/ptrr_table.sv =====
// Task table memory: one write port, one registered read port.
// Status resets to free and pid to -1 through a clearing pass; uses ptrr_pkg.
`timescale 1ns / 1ps
module ptrr_table (
   input  logic                  clock,
   input  logic                  reset,
   input  ptrr_pkg::mem_ctl_type ctl,
   output ptrr_pkg::entry_type   rd_data,
   output logic                  clear_done
);
   import ptrr_pkg::*;

   entry_type             mem [ENTRIES];
   logic [CNT_W-1:0]      clr_ff, clr_in;
   logic                  we;
   logic [IDX_W-1:0]      wa;
   entry_type             wd;

   assign clear_done = clr_ff[CNT_W-1] || (clr_ff == CNT_W'(ENTRIES));
   assign clr_in     = clear_done ? clr_ff : clr_ff + CNT_W'(1);

   always_comb begin
      we = ctl.wr_en;
      wa = ctl.wr_addr;
      wd = ctl.wr_data;
      if (!clear_done) begin
         we            = 1'b1;
         wa            = clr_ff[IDX_W-1:0];
         wd            = '0;
         wd.status     = ST_FREE;
         wd.pid        = PID_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data <= mem[ctl.rd_addr];
   end
endmodule

// ===== src/ptrr_ctrl.sv =====
// Sequencer for the task table: decodes ops, sweeps slots one per cycle.
// Drives the ptrr_table ports; uses ptrr_pkg.
`timescale 1ns / 1ps
module ptrr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear_done,
   input  logic                  csr_write,
   input  logic [15:0]           csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_op,
   input  logic [6:0]            req_slot,
   input  logic signed [15:0]    req_pid,
   input  logic signed [15:0]    req_parent_pid,
   input  logic [31:0]           req_page_base,
   input  logic [15:0]           req_sleep_ticks,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [6:0]            rsp_result_slot,
   output logic                  rsp_found,
   output logic signed [15:0]    rsp_result_pid,
   output logic [31:0]           rsp_result_page_base,
   output ptrr_pkg::mem_ctl_type ctl,
   input  ptrr_pkg::entry_type   rd_data
);
   import ptrr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_RMW_RD, S_RMW_WR, S_SCAN, S_SCAN_WR, S_DONE
   } state_type;

   state_type         state_ff;
   op_type            op_ff;
   logic [IDX_W-1:0]  cur_ff, idx_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [15:0]       pid_ff, ppid_ff, ticks_ff, dsleep_ff;
   logic [31:0]       page_ff;
   logic              accept;
   logic              slot_ok;
   logic              scan_op;
   logic              cur_op;
   logic              sched_hit;
   logic [IDX_W-1:0]  start_idx;
   logic [IDX_W-1:0]  first_idx;
   logic [IDX_W-1:0]  idx_in;
   logic [15:0]       dec;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid || !clear_done;
   assign accept    = req_valid && !req_stall;
   assign slot_ok   = 32'(req_slot) < ENTRIES;
   assign scan_op   = (req_op == OP_ALLOC) || (req_op == OP_SCHEDULE) ||
                      (req_op == OP_TICK);
   assign cur_op    = (req_op == OP_SLEEP) || (req_op == OP_EXIT) || (req_op == OP_GETPID);
   assign start_idx = (req_op == OP_ALLOC || req_op == OP_TICK) ? '0 : cur_ff + 1'b1;
   assign first_idx = cur_op ? cur_ff : (scan_op ? start_idx : req_slot[IDX_W-1:0]);
   assign idx_in    = idx_ff + 1'b1;
   assign dec       = rd_data.countdown - 16'd1;
   // scheduler found a ready slot: hold the index for the write-back
   assign sched_hit = (state_ff == S_SCAN) && (op_ff != OP_ALLOC) && (op_ff != OP_TICK) &&
                      (rd_data.status == ST_READY);

   always_comb begin
      ctl         = '0;
      ctl.rd_addr = idx_ff;
      ctl.wr_addr = idx_ff;
      ctl.wr_data = rd_data;
      case (state_ff)
         S_IDLE: begin
            ctl.rd_addr = accept ? first_idx : idx_ff;
         end
         S_RMW_WR: begin
            ctl.wr_en = 1'b1;
            case (op_ff)
               OP_NEW: begin
                  ctl.wr_data.status     = ST_NEW;
                  ctl.wr_data.pid        = pid_ff;
                  ctl.wr_data.parent_pid = ppid_ff;
                  ctl.wr_data.countdown  = dsleep_ff;
               end
               OP_READY:   ctl.wr_data.status = ST_READY;
               OP_RUNNING: ctl.wr_data.status = ST_RUNNING;
               OP_PAGE:    ctl.wr_data.page_base = page_ff;
               OP_SLEEP: begin
                  ctl.wr_data.status    = ST_BLOCKED;
                  ctl.wr_data.countdown = ticks_ff;
               end
               OP_EXIT: begin
                  ctl.wr_data.status = ST_FREE;
                  ctl.wr_data.pid    = PID_NONE;
               end
               default: ctl.wr_en = 1'b0;
            endcase
            ctl.rd_addr = cur_ff + 1'b1;
         end
         S_SCAN: begin
            ctl.rd_addr = sched_hit ? idx_ff : idx_in;
            if (op_ff == OP_TICK && rd_data.status == ST_BLOCKED) begin
               ctl.wr_en = 1'b1;
               ctl.wr_data.countdown = dec;
               if (dec == 16'd0) ctl.wr_data.status = ST_READY;
            end
         end
         S_SCAN_WR: begin
            ctl.wr_en = 1'b1;
            ctl.wr_data.status = ST_RUNNING;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cur_ff    <= '0;
         rsp_valid <= 1'b0;
         dsleep_ff <= SLEEP_DEFAULT;
      end else begin
         if (csr_write) dsleep_ff <= csr_wdata;
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff                <= op_type'(req_op);
                  pid_ff               <= req_pid;
                  ppid_ff              <= req_parent_pid;
                  page_ff              <= req_page_base;
                  ticks_ff             <= req_sleep_ticks;
                  rsp_result_slot      <= '0;
                  rsp_found            <= 1'b0;
                  rsp_result_pid       <= '0;
                  rsp_result_page_base <= '0;
                  cnt_ff               <= '0;
                  idx_ff               <= first_idx;
                  case (req_op)
                     OP_ALLOC, OP_TICK, OP_SCHEDULE: state_ff <= S_SCAN;
                     OP_NEW, OP_READY, OP_RUNNING, OP_PAGE: begin
                        state_ff <= slot_ok ? S_RMW_RD : S_DONE;
                     end
                     OP_SLEEP, OP_EXIT, OP_GETPID: state_ff <= S_RMW_RD;
                     default: state_ff <= S_DONE;
                  endcase
               end
            end
            S_RMW_RD: begin
               if (op_ff == OP_GETPID) begin
                  rsp_result_pid <= rd_data.pid;
                  state_ff       <= S_DONE;
               end else begin
                  state_ff <= S_RMW_WR;
               end
            end
            S_RMW_WR: begin
               if (op_ff == OP_SLEEP || op_ff == OP_EXIT) begin
                  idx_ff   <= cur_ff + 1'b1;
                  cnt_ff   <= '0;
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_DONE;
               end
            end
            S_SCAN: begin
               // scheduler checks up to ENTRIES-1 slots, alloc up to all of them, tick all of them
               if (!sched_hit) idx_ff <= idx_in;
               cnt_ff <= cnt_ff + 1'b1;
               if (op_ff == OP_ALLOC) begin
                  if (rd_data.status == ST_FREE) begin
                     rsp_result_slot <= 7'(idx_ff);
                     rsp_found       <= 1'b1;
                     state_ff        <= S_DONE;
                  end else if (cnt_ff == CNT_W'(ENTRIES - 1)) begin
                     state_ff <= S_DONE;
                  end
               end else if (op_ff == OP_TICK) begin
                  if (cnt_ff == CNT_W'(ENTRIES - 1)) state_ff <= S_DONE;
               end else begin
                  if (sched_hit) begin
                     cur_ff               <= idx_ff;
                     rsp_result_slot      <= 7'(idx_ff);
                     rsp_found            <= 1'b1;
                     rsp_result_page_base <= rd_data.page_base;
                     state_ff             <= S_SCAN_WR;
                  end else if (cnt_ff == CNT_W'(ENTRIES - 2)) begin
                     cur_ff   <= '0;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_SCAN_WR: state_ff <= S_DONE;
            S_DONE: begin
               rsp_valid <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== src/ptrr_checker.sv =====
// Port-level checks for the process table round-robin scheduler.
// Bound to the top level; uses ptrr_pkg.
`timescale 1ns / 1ps
module ptrr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [6:0]         rsp_result_slot,
   input logic               rsp_found,
   input logic [31:0]        rsp_result_page_base
);
   import ptrr_pkg::*;

   // one word in flight: no accept while a result waits
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept with pending result");

   a_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result too early");

   a_nf: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_result_slot == 7'd0 &&
      rsp_result_page_base == 32'd0)) else $error("not-found result not zero");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_result_slot)))
      else $error("stalled result changed");
endmodule

bind process_table_round_robin_scheduler ptrr_checker u_ptrr_checker (.*);
